[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vibration qualifier checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define VQPT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VQPT_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/vqpt_pkg.sv]
// ----------------------------------------------------------------------------
// vqpt_pkg
// Types and constants of the vibration qualifier and relay pulse trigger.
// ----------------------------------------------------------------------------
package vqpt_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int SAMPLE_INTERVAL = 5;
	localparam int DEBOUNCE_TICKS = 20;
	localparam int COOLDOWN_TICKS = 500;

	localparam int CNT_W = 3;
	localparam int RUN_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SAMPLE_W = 12;
	localparam int TICKS_W = 16;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_COOL = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIGITAL_MODE     = 3'd0,
		REG_ACTIVE_LEVEL     = 3'd1,
		REG_ANALOG_THRESHOLD = 3'd2,
		REG_TRIGGER_SAMPLES  = 3'd3,
		REG_RELEASE_SAMPLES  = 3'd4,
		REG_HOLD_TICKS       = 3'd5,
		REG_LOCKOUT_TICKS    = 3'd6,
		REG_PULSE_TICKS      = 3'd7
	} cfg_reg_t;

	function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
		return (v == RUN_MAX) ? v : v + 1'b1;
	endfunction

endpackage

[rtl/vibration_qualifier_pulse_trigger_unit.sv]
// ----------------------------------------------------------------------------
// vibration_qualifier_pulse_trigger_unit
// Sampled vibration qualifier with debounce, hold, lockout and relay pulse.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one millisecond tick and yields exactly
// one result transfer. A tick is taken into an input register and its whole
// state update (sampling, run counters, detect and release qualification and
// the relay phase step) is computed combinationally into the result register, so
// the block sustains one tick per clock cycle unless the output stalls. The
// input side keeps accepting while a result waits to be taken, and stalls only
// when both the input register and the result register are full. Configuration
// writes take effect at once and are meant for times when no tick is in flight.
module vibration_qualifier_pulse_trigger_unit
	import vqpt_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  sensor_level,
	input  logic                  edge_seen,
	input  logic [SAMPLE_W-1:0]   analog_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  relay_on,
	output logic                  vibration_now,
	output logic [1:0]            pulse_phase,
	output logic [SAMPLE_W-1:0]   sample_value,
	output logic                  detect_event,
	output logic                  release_event
);

	typedef logic [TIME_WIDTH-1:0] tw_t;

	localparam logic [CNT_W-1:0]   SAMPLE_CNT = CNT_W'(SAMPLE_INTERVAL);
	localparam logic [TICKS_W-1:0] DEBOUNCE_T = TICKS_W'(DEBOUNCE_TICKS);
	localparam logic [TICKS_W-1:0] COOLDOWN_T = TICKS_W'(COOLDOWN_TICKS);

	// Configuration registers
	logic                  digital_mode_q;
	logic                  active_level_q;
	logic [SAMPLE_W-1:0]   analog_threshold_q;
	logic [RUN_W-1:0]      trigger_samples_q;
	logic [RUN_W-1:0]      release_samples_q;
	logic [TICKS_W-1:0]    hold_ticks_q;
	logic [TICKS_W-1:0]    lockout_ticks_q;
	logic [TICKS_W-1:0]    pulse_ticks_q;

	// Input register
	logic                  valid_s1;
	logic                  level_s1;
	logic                  edge_s1;
	logic [SAMPLE_W-1:0]   sample_s1;

	// Tick state
	tw_t                   tick_time_q;
	tw_t                   detect_time_q;
	tw_t                   phase_time_q;
	logic [CNT_W-1:0]      countdown_q;
	logic                  edge_latch_q;
	logic [RUN_W-1:0]      active_run_q;
	logic [RUN_W-1:0]      quiet_run_q;
	logic                  detected_q;
	logic                  ever_trig_q;
	phase_t                phase_q;
	logic [SAMPLE_W-1:0]   held_value_q;

	// Next state
	tw_t                   detect_time_d;
	tw_t                   phase_time_d;
	logic [CNT_W-1:0]      countdown_d;
	logic                  edge_latch_d;
	logic [RUN_W-1:0]      active_run_d;
	logic [RUN_W-1:0]      quiet_run_d;
	logic                  detected_d;
	logic                  ever_trig_d;
	phase_t                phase_d;
	logic [SAMPLE_W-1:0]   held_value_d;
	logic                  det_ev;
	logic                  rel_ev;

	// Result register
	logic                  out_valid_q;
	logic                  relay_q;
	logic                  vib_q;
	phase_t                phase_out_q;
	logic [SAMPLE_W-1:0]   sample_out_q;
	logic                  det_ev_q;
	logic                  rel_ev_q;

	logic                  s1_adv;
	logic                  s1_fire;
	logic                  in_fire;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_adv;
	assign in_stall = valid_s1 && !s1_adv;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digital_mode_q     <= 1'b1;
			active_level_q     <= 1'b0;
			analog_threshold_q <= SAMPLE_W'(500);
			trigger_samples_q  <= RUN_W'(1);
			release_samples_q  <= RUN_W'(60);
			hold_ticks_q       <= TICKS_W'(300);
			lockout_ticks_q    <= TICKS_W'(1500);
			pulse_ticks_q      <= TICKS_W'(200);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIGITAL_MODE:     digital_mode_q     <= cfg_data[0];
				REG_ACTIVE_LEVEL:     active_level_q     <= cfg_data[0];
				REG_ANALOG_THRESHOLD: analog_threshold_q <= cfg_data[SAMPLE_W-1:0];
				REG_TRIGGER_SAMPLES:  trigger_samples_q  <= cfg_data[RUN_W-1:0];
				REG_RELEASE_SAMPLES:  release_samples_q  <= cfg_data[RUN_W-1:0];
				REG_HOLD_TICKS:       hold_ticks_q       <= cfg_data;
				REG_LOCKOUT_TICKS:    lockout_ticks_q    <= cfg_data;
				REG_PULSE_TICKS:      pulse_ticks_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			level_s1  <= sensor_level;
			edge_s1   <= edge_seen;
			sample_s1 <= analog_sample;
		end
	end

	// Sampling, qualification and relay phase step for the tick in the input register.
	always_comb begin
		logic             sample_tick;
		logic             act;
		logic             det_cond;
		logic             lock_ok;
		tw_t              el;
		tw_t              ph_el;
		phase_t           ph_mid;
		tw_t              pt_mid;

		sample_tick   = (countdown_q >= SAMPLE_CNT);
		detect_time_d = detect_time_q;
		countdown_d   = countdown_q + 1'b1;
		edge_latch_d  = edge_latch_q | edge_s1;
		active_run_d  = active_run_q;
		quiet_run_d   = quiet_run_q;
		detected_d    = detected_q;
		ever_trig_d   = ever_trig_q;
		held_value_d  = held_value_q;
		det_ev        = 1'b0;
		rel_ev        = 1'b0;
		ph_mid        = phase_q;
		pt_mid        = phase_time_q;

		if (digital_mode_q) begin
			act = edge_latch_q || edge_s1 || (level_s1 == active_level_q);
		end else begin
			act = (sample_s1 > analog_threshold_q);
		end

		el = tick_time_q - detect_time_q;
		lock_ok = !ever_trig_q ||
			((el >= TIME_WIDTH'(lockout_ticks_q)) && (el >= TIME_WIDTH'(DEBOUNCE_T)));

		if (sample_tick) begin
			countdown_d  = CNT_W'(1);
			edge_latch_d = 1'b0;
			if (digital_mode_q) begin
				held_value_d = act ? '0 : SAMPLE_W'(1);
			end else begin
				held_value_d = sample_s1;
			end
			active_run_d = act ? sat_inc(active_run_q) : '0;
			quiet_run_d  = act ? '0 : sat_inc(quiet_run_q);
		end

		det_cond = (active_run_d >= trigger_samples_q) && !detected_q;

		if (sample_tick && det_cond) begin
			if (lock_ok) begin
				detected_d    = 1'b1;
				ever_trig_d   = 1'b1;
				detect_time_d = tick_time_q;
				det_ev        = 1'b1;
				if (phase_q != PH_TRIG && phase_q != PH_COOL) begin
					ph_mid = PH_TRIG;
					pt_mid = tick_time_q;
				end
			end
		end else if (sample_tick && (quiet_run_d >= release_samples_q) && detected_q) begin
			if (el >= TIME_WIDTH'(hold_ticks_q)) begin
				detected_d = 1'b0;
				rel_ev     = 1'b1;
			end
		end

		ph_el        = tick_time_q - pt_mid;
		phase_d      = ph_mid;
		phase_time_d = pt_mid;
		unique case (ph_mid)
			PH_TRIG: begin
				if (ph_el >= TIME_WIDTH'(pulse_ticks_q)) begin
					phase_d      = PH_COOL;
					phase_time_d = tick_time_q;
				end
			end
			PH_COOL: begin
				if (ph_el >= TIME_WIDTH'(COOLDOWN_T)) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_time_q   <= '0;
			detect_time_q <= '0;
			phase_time_q  <= '0;
			countdown_q   <= '0;
			edge_latch_q  <= 1'b0;
			active_run_q  <= '0;
			quiet_run_q   <= '0;
			detected_q    <= 1'b0;
			ever_trig_q   <= 1'b0;
			phase_q       <= PH_IDLE;
			held_value_q  <= '0;
		end else if (s1_fire) begin
			tick_time_q   <= tick_time_q + 1'b1;
			detect_time_q <= detect_time_d;
			phase_time_q  <= phase_time_d;
			countdown_q   <= countdown_d;
			edge_latch_q  <= edge_latch_d;
			active_run_q  <= active_run_d;
			quiet_run_q   <= quiet_run_d;
			detected_q    <= detected_d;
			ever_trig_q   <= ever_trig_d;
			phase_q       <= phase_d;
			held_value_q  <= held_value_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			relay_q      <= (phase_d == PH_TRIG);
			vib_q        <= detected_d;
			phase_out_q  <= phase_d;
			sample_out_q <= held_value_d;
			det_ev_q     <= det_ev;
			rel_ev_q     <= rel_ev;
		end
	end

	assign out_valid     = out_valid_q;
	assign relay_on      = relay_q;
	assign vibration_now = vib_q;
	assign pulse_phase   = phase_out_q;
	assign sample_value  = sample_out_q;
	assign detect_event  = det_ev_q;
	assign release_event = rel_ev_q;

endmodule

[rtl/vqpt_checker.sv]
// ----------------------------------------------------------------------------
// vqpt_checker
// Port-level assertions for the vibration qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vqpt_checker
	import vqpt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                relay_on,
	input logic                vibration_now,
	input logic [1:0]          pulse_phase,
	input logic                detect_event,
	input logic                release_event
);

	`VQPT_ASSERT(a_relay_phase, clk, arst_n, out_valid |-> (relay_on == (pulse_phase == 2'(PH_TRIG))), "relay_on disagrees with pulse phase")
	`VQPT_ASSERT(a_phase_code, clk, arst_n, out_valid |-> (pulse_phase != 2'd3), "unused pulse phase code")
	`VQPT_ASSERT(a_detect_state, clk, arst_n, (out_valid && detect_event) |-> (vibration_now && !release_event), "detect transfer without detection")
	`VQPT_ASSERT(a_release_state, clk, arst_n, (out_valid && release_event) |-> !vibration_now, "release transfer while still detected")
	// The result register is held clear by the asynchronous reset, so the next edge shows no result.
	`VQPT_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid, "result valid right after reset")

endmodule

bind vibration_qualifier_pulse_trigger_unit vqpt_checker u_vqpt_checker (.*);

[tb/vibration_qualifier_pulse_trigger_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vibration_qualifier_pulse_trigger_unit_test
// Self-checking bench for the vibration qualifier and relay pulse trigger.
// A scoreboard tracks sampling, run counters, detect and release qualification
// and the relay phase for every accepted tick. Each result transfer is checked
// field by field against the oldest prediction, under several register settings
// and under random idling and stalling on both channels.
// ----------------------------------------------------------------------------
module vibration_qualifier_pulse_trigger_unit_test;
	import vqpt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic                relay_on;
		logic                vibration_now;
		logic [1:0]          pulse_phase;
		logic [SAMPLE_W-1:0] sample_value;
		logic                detect_event;
		logic                release_event;
	} tick_result_t;

	class vibration_tracker;
		bit                      digital_mode;
		bit                      active_level;
		bit [SAMPLE_W-1:0]       analog_threshold;
		bit [RUN_W-1:0]          trigger_samples;
		bit [RUN_W-1:0]          release_samples;
		bit [TICKS_W-1:0]        hold_ticks;
		bit [TICKS_W-1:0]        lockout_ticks;
		bit [TICKS_W-1:0]        pulse_ticks;
		bit [TIME_WIDTH_DEF-1:0] tick_time;
		bit [TIME_WIDTH_DEF-1:0] detect_time;
		bit [TIME_WIDTH_DEF-1:0] phase_time;
		bit [CNT_W-1:0]          since_sample;
		bit                      edge_latch;
		bit [RUN_W-1:0]          active_run;
		bit [RUN_W-1:0]          quiet_run;
		bit                      detected;
		bit                      ever_triggered;
		phase_t                  phase;
		bit [SAMPLE_W-1:0]       held_value;
		tick_result_t            expected_ticks[$];
		int                      mismatches;

		function new();
			digital_mode = 1'b1;
			active_level = 1'b0;
			analog_threshold = 500;
			trigger_samples = 1;
			release_samples = 60;
			hold_ticks = 300;
			lockout_ticks = 1500;
			pulse_ticks = 200;
			phase = PH_IDLE;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DIGITAL_MODE:     digital_mode = data[0];
				REG_ACTIVE_LEVEL:     active_level = data[0];
				REG_ANALOG_THRESHOLD: analog_threshold = data[SAMPLE_W-1:0];
				REG_TRIGGER_SAMPLES:  trigger_samples = data[RUN_W-1:0];
				REG_RELEASE_SAMPLES:  release_samples = data[RUN_W-1:0];
				REG_HOLD_TICKS:       hold_ticks = data[TICKS_W-1:0];
				REG_LOCKOUT_TICKS:    lockout_ticks = data[TICKS_W-1:0];
				REG_PULSE_TICKS:      pulse_ticks = data[TICKS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_tick(bit level, bit edge_in, bit [SAMPLE_W-1:0] adc);
			bit [TIME_WIDTH_DEF-1:0] now;
			bit [TIME_WIDTH_DEF-1:0] elapsed;
			bit act;
			bit det_ev;
			bit rel_ev;
			tick_result_t r;
			now = tick_time;
			det_ev = 1'b0;
			rel_ev = 1'b0;
			if (since_sample >= SAMPLE_INTERVAL) begin
				since_sample = 1;
				if (digital_mode) begin
					// An edge in the sampling tick itself counts for this sample.
					act = edge_latch || edge_in || (level == active_level);
					held_value = {{(SAMPLE_W-1){1'b0}}, !act};
				end else begin
					act = adc > analog_threshold;
					held_value = adc;
				end
				edge_latch = 1'b0;
				if (act) begin
					if (active_run != RUN_MAX) active_run++;
					quiet_run = '0;
				end else begin
					if (quiet_run != RUN_MAX) quiet_run++;
					active_run = '0;
				end
				elapsed = now - detect_time;
				if (active_run >= trigger_samples && !detected) begin
					if (!ever_triggered ||
							(elapsed >= lockout_ticks && elapsed >= DEBOUNCE_TICKS)) begin
						detected = 1'b1;
						ever_triggered = 1'b1;
						detect_time = now;
						det_ev = 1'b1;
						// A detection while a pulse or cooldown runs fires no new pulse.
						if (phase != PH_TRIG && phase != PH_COOL) begin
							phase = PH_TRIG;
							phase_time = now;
						end
					end
				end else if (quiet_run >= release_samples && detected &&
						elapsed >= hold_ticks) begin
					detected = 1'b0;
					rel_ev = 1'b1;
				end
			end else begin
				since_sample++;
				edge_latch |= edge_in;
			end
			elapsed = now - phase_time;
			case (phase)
				PH_TRIG: begin
					if (elapsed >= pulse_ticks) begin
						phase = PH_COOL;
						phase_time = now;
					end
				end
				PH_COOL: begin
					if (elapsed >= COOLDOWN_TICKS) phase = PH_IDLE;
				end
				default: phase = PH_IDLE;
			endcase
			tick_time = now + 1;
			r.relay_on = (phase == PH_TRIG);
			r.vibration_now = detected;
			r.pulse_phase = phase;
			r.sample_value = held_value;
			r.detect_event = det_ev;
			r.release_event = rel_ev;
			expected_ticks.push_back(r);
		endfunction

		function void check_field(string name, int unsigned exp, int unsigned got);
			if (exp != got) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, exp,
						got);
			end
		endfunction

		function void check_tick(tick_result_t got);
			tick_result_t exp;
			if (expected_ticks.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result transfer at %0t with no tick pending", $realtime);
				return;
			end
			exp = expected_ticks.pop_front();
			check_field("relay_on", exp.relay_on, got.relay_on);
			check_field("vibration_now", exp.vibration_now, got.vibration_now);
			check_field("pulse_phase", exp.pulse_phase, got.pulse_phase);
			check_field("sample_value", exp.sample_value, got.sample_value);
			check_field("detect_event", exp.detect_event, got.detect_event);
			check_field("release_event", exp.release_event, got.release_event);
		endfunction

		function int unsigned pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  sensor_level = 1'b0;
	logic                  edge_seen = 1'b0;
	logic [SAMPLE_W-1:0]   analog_sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  relay_on;
	logic                  vibration_now;
	logic [1:0]            pulse_phase;
	logic [SAMPLE_W-1:0]   sample_value;
	logic                  detect_event;
	logic                  release_event;

	vibration_tracker tracker;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_off_req = 1'b0;
	int  hold_off_left = 0;
	int  idle_cycles = 0;
	int  burst_left = 0;
	bit  burst_active = 1'b0;
	int  noise_pct = 15;

	vibration_qualifier_pulse_trigger_unit i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver side; a requested hold-off keeps stall high while its countdown runs.
	always @(negedge clk) begin
		if (hold_off_req) begin
			hold_off_left = HOLD_OFF_CYCLES;
			hold_off_req = 1'b0;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_tick({relay_on, vibration_now, pulse_phase, sample_value, detect_event,
				release_event});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_tick(bit level, bit edge_in, bit [SAMPLE_W-1:0] adc);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sensor_level <= level;
		edge_seen <= edge_in;
		analog_sample <= adc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_tick(level, edge_in, adc);
		@(negedge clk);
	endtask

	// Alternates vibration bursts and quiet stretches sized from the current
	// run-length settings, with some fully random ticks mixed in.
	task automatic next_tick(output bit level, output bit edge_in, output bit [SAMPLE_W-1:0] adc);
		int thr;
		int quiet_max;
		thr = int'(tracker.analog_threshold);
		if (burst_left == 0) begin
			burst_active = !burst_active;
			quiet_max = 5 * tracker.release_samples + 40;
			if (quiet_max > 400) quiet_max = 400;
			burst_left = burst_active ? $urandom_range(5 * tracker.trigger_samples + 15, 1) :
				$urandom_range(quiet_max, 1);
		end
		burst_left--;
		level = 1'($urandom);
		edge_in = 1'($urandom);
		adc = SAMPLE_W'($urandom);
		if ($urandom_range(99) >= noise_pct) begin
			if (burst_active) begin
				level = ($urandom_range(99) < 80) ? tracker.active_level : !tracker.active_level;
				edge_in = ($urandom_range(99) < 30);
				if (thr < SAMPLE_MAX) adc = SAMPLE_W'($urandom_range(SAMPLE_MAX, thr + 1));
			end else begin
				level = !tracker.active_level;
				edge_in = ($urandom_range(99) < 3);
				adc = SAMPLE_W'($urandom_range(thr, 0));
			end
		end
	endtask

	task automatic apply_setting(bit dm, bit al, int thr, int trig, int rel, int hold, int lock,
			int pulse);
		bit [CFG_DATA_W-1:0] vals[8];
		int widths[8];
		bit [CFG_DATA_W-1:0] data;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		vals = '{CFG_DATA_W'(dm), CFG_DATA_W'(al), CFG_DATA_W'(thr), CFG_DATA_W'(trig),
			CFG_DATA_W'(rel), CFG_DATA_W'(hold), CFG_DATA_W'(lock), CFG_DATA_W'(pulse)};
		widths = '{1, 1, SAMPLE_W, RUN_W, RUN_W, TICKS_W, TICKS_W, TICKS_W};
		for (int i = 0; i < 8; i++) begin
			// Bits above the register width are filled at random and must be ignored.
			data = vals[i] | CFG_DATA_W'($urandom << widths[i]);
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= data;
			tracker.write_reg(cfg_reg_t'(i), data);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int items, idle_mode_t mode, int hold_off_at);
		bit lv;
		bit ed;
		bit [SAMPLE_W-1:0] adc;
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 86; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 86; end
			default:       begin send_idle_pct = 30; stall_pct = 30; end
		endcase
		for (int i = 0; i < items; i++) begin
			if (i == hold_off_at) hold_off_req = 1'b1;
			next_tick(lv, ed, adc);
			send_tick(lv, ed, adc);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		tracker = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: digital mode, edges latched between samples and taken
		// on the sampling tick, first detection with no earlier trigger.
		for (int i = 0; i < 12; i++)
			send_tick(i[0], (i % 4) == 1, SAMPLE_W'((i % 2) ? SAMPLE_MAX : 0));
		in_valid <= 1'b0;

		// Analog mode at the lowest threshold, with no hold, lockout or pulse time.
		apply_setting(1'b0, 1'b1, 0, 1, 1, 0, 0, 0);
		for (int i = 0; i < 10; i++)
			send_tick(i[1], i[0], SAMPLE_W'((i % 3 == 0) ? 0 : ((i % 3 == 1) ? 1 : SAMPLE_MAX)));
		in_valid <= 1'b0;

		apply_setting(1'b1, 1'b1, 500, 2, 3, 30, 60, 15);
		run_phase(180, IDLE_NONE, 90);
		apply_setting(1'b0, 1'b0, 2048, 1, 1, 0, 0, 0);
		run_phase(180, IDLE_SENDER, -1);
		apply_setting(1'b0, 1'b0, SAMPLE_MAX, 255, 255, 65535, 65535, 65535);
		run_phase(150, IDLE_RECEIVER, -1);
		apply_setting(1'b1, 1'b0, 0, 0, 0, 10, 25, 40);
		run_phase(200, IDLE_BOTH, -1);
		// Pulse longer than the lockout, so detections land while the relay runs.
		apply_setting(1'b0, 1'b1, 1000, 2, 4, 40, 100, 300);
		run_phase(200, IDLE_NONE, 120);
		// Lockout below the debounce time, so debounce decides.
		apply_setting(1'b1, 1'b1, SAMPLE_MAX, 1, 2, 5, 10, 5);
		run_phase(200, IDLE_SENDER, -1);

		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
